// ----- rtl/core/mva_pkg.sv -----
package mva_pkg;

  // message format
  localparam logic [31:0] MSG_MAGIC     = 32'h4252_504d;
  localparam logic [15:0] MSG_VERSION   = 16'd1;
  localparam logic [15:0] MSG_TYPE_DATA = 16'd2;
  localparam logic [15:0] MSG_TYPE_ACK  = 16'd3;
  localparam int          HDR_BYTES     = 16;
  localparam int          BUF_BYTES     = 256;
  localparam int          HDR_WORDS     = 4;
  localparam int          QUEUE_DEPTH   = 2;

  // byte offsets of header fields
  localparam int OFS_VERSION  = 4;
  localparam int OFS_TYPE     = 6;
  localparam int OFS_SEQ      = 8;
  localparam int OFS_PLEN     = 12;
  localparam int OFS_RESERVED = 14;

  // header word indexes of the ack
  localparam logic [5:0] WORD_MAGIC = 6'd0;
  localparam logic [5:0] WORD_VTYPE = 6'd1;
  localparam logic [5:0] WORD_SEQ   = 6'd2;
  localparam logic [5:0] WORD_PLEN  = 6'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       frame_end;
  } in_t;

  typedef struct packed {
    logic [31:0] out_word;
    logic [2:0]  out_valid_bytes;
    logic        out_last;
  } out_t;

  // one ack to send
  typedef struct packed {
    logic        bank;
    logic [31:0] seq;
    logic [7:0]  plen;
  } job_t;

  // payload byte write into the buffer
  typedef struct packed {
    logic       en;
    logic       bank;
    logic [5:0] row;
    logic [1:0] lane;
    logic [7:0] data;
  } pay_wr_t;

  // back side finished reading a bank
  typedef struct packed {
    logic en;
    logic bank;
  } done_t;

endpackage

// ----- rtl/core/mva_front.sv -----
module mva_front import mva_pkg::*; #(
  parameter int PAYLOAD_LIMIT = 240
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    rx_valid,
  output logic    rx_stall,
  input  in_t     rx_data,
  input  done_t   done,
  output pay_wr_t wr,
  output logic    push,
  output job_t    job
);

  logic [8:0] byte_count;
  logic       overflow_flag;
  logic       wr_bank;
  logic [1:0] busy;
  logic [7:0] hdr [HDR_BYTES];
  logic [7:0] hdr_cur [HDR_BYTES];

  logic        accept;
  logic        stored;
  logic [8:0]  count_next;
  logic        ovf;
  logic [7:0]  pay_ofs;
  logic [31:0] magic;
  logic [15:0] version;
  logic [15:0] msg_type;
  logic [15:0] plen16;
  logic [15:0] reserved;
  logic        ok;

  assign rx_stall = busy[wr_bank];
  assign accept   = rx_valid && !rx_stall;
  assign stored   = !byte_count[8];
  assign count_next = byte_count + {8'd0, stored};
  assign ovf      = overflow_flag || !stored;
  assign pay_ofs  = byte_count[7:0] - 8'(HDR_BYTES);

  // header as it stands including the current byte
  always_comb begin
    for (int i = 0; i < HDR_BYTES; i++) begin
      hdr_cur[i] = (stored && byte_count == 9'(i)) ? rx_data.in_byte : hdr[i];
    end
  end

  assign magic    = {hdr_cur[3], hdr_cur[2], hdr_cur[1], hdr_cur[0]};
  assign version  = {hdr_cur[OFS_VERSION + 1], hdr_cur[OFS_VERSION]};
  assign msg_type = {hdr_cur[OFS_TYPE + 1], hdr_cur[OFS_TYPE]};
  assign plen16   = {hdr_cur[OFS_PLEN + 1], hdr_cur[OFS_PLEN]};
  assign reserved = {hdr_cur[OFS_RESERVED + 1], hdr_cur[OFS_RESERVED]};

  // frame checks at the final byte
  assign ok = !ovf && (count_next >= 9'(HDR_BYTES)) && magic == MSG_MAGIC &&
              version == MSG_VERSION && reserved == 16'd0 &&
              plen16 <= 16'(PAYLOAD_LIMIT) &&
              {8'd0, count_next} == 17'(HDR_BYTES) + {1'b0, plen16} &&
              msg_type == MSG_TYPE_DATA;

  // payload byte write
  always_comb begin
    wr.en   = accept && stored && byte_count >= 9'(HDR_BYTES) &&
              pay_ofs < 8'(PAYLOAD_LIMIT);
    wr.bank = wr_bank;
    wr.row  = pay_ofs[7:2];
    wr.lane = pay_ofs[1:0];
    wr.data = rx_data.in_byte;
  end

  // job to the queue
  assign push     = accept && rx_data.frame_end && ok;
  assign job.bank = wr_bank;
  assign job.seq  = {hdr_cur[OFS_SEQ + 3], hdr_cur[OFS_SEQ + 2],
                     hdr_cur[OFS_SEQ + 1], hdr_cur[OFS_SEQ]};
  assign job.plen = plen16[7:0];

  // header bytes
  always_ff @(posedge clk) begin
    if (accept && stored && byte_count < 9'(HDR_BYTES)) begin
      hdr[byte_count[3:0]] <= rx_data.in_byte;
    end
  end

  // frame counters and bank ownership
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      overflow_flag <= 1'b0;
      wr_bank       <= 1'b0;
      busy          <= '0;
    end else begin
      if (done.en) begin
        busy[done.bank] <= 1'b0;
      end
      if (accept) begin
        if (rx_data.frame_end) begin
          byte_count    <= '0;
          overflow_flag <= 1'b0;
        end else begin
          byte_count    <= count_next;
          overflow_flag <= ovf;
        end
      end
      if (push) begin
        busy[wr_bank] <= 1'b1;
        wr_bank       <= !wr_bank;
      end
    end
  end

endmodule

// ----- rtl/core/mva_queue.sv -----
module mva_queue import mva_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic nonempty,
  output job_t head
);

  job_t       entry [QUEUE_DEPTH];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign nonempty = count != 2'd0;
  assign head     = entry[rptr];

  // entries
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= push_job;
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- rtl/core/mva_back.sv -----
module mva_back import mva_pkg::*; #(
  parameter int PAYLOAD_LIMIT = 240
) (
  input  logic    clk,
  input  logic    rst,
  input  pay_wr_t wr,
  input  logic    job_ready,
  input  job_t    job,
  output logic    pop,
  output done_t   done,
  output logic    tx_valid,
  input  logic    tx_stall,
  output out_t    tx_data
);

  localparam int ROWS  = (PAYLOAD_LIMIT + 3) / 4;
  localparam int DEPTH = 2 * ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [3:0][7:0] mem [DEPTH];
  logic [3:0][7:0] rdata;

  logic        active;
  logic        job_bank;
  logic [31:0] job_seq;
  logic [7:0]  job_plen;
  logic [5:0]  wi;
  logic [5:0]  last_wi;
  logic [2:0]  last_cnt;

  logic        s1_valid;
  logic        s1_pay;
  logic [31:0] s1_hdr;
  logic [2:0]  s1_cnt;
  logic        s1_last;

  logic          advance;
  logic          issue;
  logic          issue_last;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [5:0]    rd_row;
  logic [8:0]    total;
  logic [9:0]    total_up;
  logic [31:0]   hdr_word;
  logic [31:0]   word;

  assign advance    = !tx_valid || !tx_stall;
  assign issue      = active && advance;
  assign issue_last = issue && wi == last_wi;
  assign pop        = job_ready && !active;
  assign done.en    = issue_last;
  assign done.bank  = job_bank;

  assign wr_addr = (wr.bank ? AW'(ROWS) : '0) + AW'(wr.row);
  assign rd_row  = (wi >= 6'(HDR_WORDS)) ? wi - 6'(HDR_WORDS) : '0;
  assign rd_addr = (job_bank ? AW'(ROWS) : '0) + AW'(rd_row);

  // payload buffer, one byte lane per column
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr][wr.lane] <= wr.data;
    end
    if (advance) begin
      rdata <= mem[rd_addr];
    end
  end

  // ack length from the payload length
  assign total    = 9'(HDR_BYTES) + {1'b0, job.plen};
  assign total_up = {1'b0, total} + 10'd3;

  // ack header words
  always_comb begin
    case (wi)
      WORD_MAGIC: hdr_word = MSG_MAGIC;
      WORD_VTYPE: hdr_word = {MSG_TYPE_ACK, MSG_VERSION};
      WORD_SEQ:   hdr_word = job_seq;
      WORD_PLEN:  hdr_word = {16'd0, 8'd0, job_plen};
      default:    hdr_word = '0;
    endcase
  end

  // job sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (pop) begin
      active <= 1'b1;
    end else if (issue_last) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_bank <= job.bank;
      job_seq  <= job.seq;
      job_plen <= job.plen;
      wi       <= '0;
      last_wi  <= 6'((total_up >> 2) - 10'd1);
      last_cnt <= (total[1:0] == 2'd0) ? 3'd4 : {1'b0, total[1:0]};
    end else if (issue) begin
      wi <= wi + 6'd1;
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= active;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_pay  <= wi >= 6'(HDR_WORDS);
      s1_hdr  <= hdr_word;
      s1_cnt  <= (wi == last_wi) ? last_cnt : 3'd4;
      s1_last <= wi == last_wi;
    end
  end

  // word with unused high bytes cleared
  always_comb begin
    word = s1_pay ? rdata : s1_hdr;
    for (int j = 0; j < 4; j++) begin
      if (3'(j) >= s1_cnt) begin
        word[8*j +: 8] = 8'd0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_valid <= 1'b0;
    end else if (advance) begin
      tx_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      tx_data.out_word        <= word;
      tx_data.out_valid_bytes <= s1_cnt;
      tx_data.out_last        <= s1_last;
    end
  end

endmodule

// ----- rtl/core/message_validate_and_echo_ack.sv -----
// Message validator with echo acknowledgement.
// rx channel: one message byte per request (in_byte, frame_end on the final
// byte), valid/stall handshake; rx_stall is driven here.
// tx channel: the ack frame as 32-bit little-endian words, out_valid_bytes
// valid from the low end, out_last on the final word.
// Throughput: one byte per cycle in while rx_stall is low, one word per
// cycle out while tx_stall is low. The payload buffer has two banks, so a
// new frame fills one bank while the ack of the previous frame drains from
// the other; rx_stall rises only when both banks hold acks still waiting to
// be sent. The first ack word is valid once the job has passed the queue,
// the job registers, the read stage and the output register; a gap parts
// two acks as the sender loads the next job from the two-entry queue.
// Frames that fail a check, or are not of type data, produce no output.
// Reset clears the byte counter, overflow flag, bank ownership, queue and
// output register; no buffer clearing is needed.
// When tx_stall is high with tx_valid set, the output word holds and the
// read pipeline waits; byte intake continues until both banks are taken.
module message_validate_and_echo_ack import mva_pkg::*; #(
  parameter int PAYLOAD_LIMIT = 240
) (
  input  logic clk,
  input  logic rst,
  input  logic rx_valid,
  output logic rx_stall,
  input  in_t  rx_data,
  output logic tx_valid,
  input  logic tx_stall,
  output out_t tx_data
);

  pay_wr_t wr;
  done_t   done;
  logic    push;
  job_t    push_job;
  logic    pop;
  logic    nonempty;
  job_t    head;

  // byte intake and frame checks
  mva_front #(.PAYLOAD_LIMIT(PAYLOAD_LIMIT)) u_front (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_stall (rx_stall),
    .rx_data  (rx_data),
    .done     (done),
    .wr       (wr),
    .push     (push),
    .job      (push_job)
  );

  // pending acks
  mva_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .nonempty (nonempty),
    .head     (head)
  );

  // ack sender
  mva_back #(.PAYLOAD_LIMIT(PAYLOAD_LIMIT)) u_back (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .job_ready (nonempty),
    .job       (head),
    .pop       (pop),
    .done      (done),
    .tx_valid  (tx_valid),
    .tx_stall  (tx_stall),
    .tx_data   (tx_data)
  );

endmodule
